// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the parser RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge, skipped while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check that a condition never holds on a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- rtl/core/tlvp_pkg.sv -----
// Types and codes of the TLV update-response parser.
// Depends on nothing; used by tlvp_core and the top level.
package tlvp_pkg;

    // Record ids on the wire
    localparam logic [7:0] HOST_ID   = 8'd1;
    localparam logic [7:0] PORT_ID   = 8'd2;
    localparam logic [7:0] PATH_ID   = 8'd3;
    localparam logic [7:0] UPDATE_ID = 8'd4;

    // Parse phases
    localparam logic [1:0] PH_ID  = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_VAL = 2'd2;

    // Record kinds
    localparam logic [1:0] K_HOST = 2'd0;
    localparam logic [1:0] K_PORT = 2'd1;
    localparam logic [1:0] K_PATH = 2'd2;
    localparam logic [1:0] K_UPD  = 2'd3;

    // Event kinds
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_HOST_CHAR = 3'd1;
    localparam logic [2:0] EV_PATH_CHAR = 3'd2;
    localparam logic [2:0] EV_PORT      = 3'd3;
    localparam logic [2:0] EV_UPDATE    = 3'd4;
    localparam logic [2:0] EV_EMPTY_END = 3'd5;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
    localparam logic [2:0] ERR_PORT_LEN = 3'd2;
    localparam logic [2:0] ERR_BOOL_LEN = 3'd3;
    localparam logic [2:0] ERR_TRUNC    = 3'd4;

    // Fixed lengths of the numeric records
    localparam logic [7:0] PORT_LEN = 8'd4;
    localparam logic [7:0] BOOL_LEN = 8'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic        string_field;
        logic [7:0]  char_value;
        logic        string_last;
        logic [31:0] port_value;
        logic        update_flag;
        logic        message_end;
        logic [2:0]  error_code;
    } t_out_word;

endpackage

// ----- rtl/core/tlvp_core.sv -----
// Parse state and per-byte decode of the TLV update-response parser.
// Depends on tlvp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlvp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  tlvp_pkg::t_in_word   i_word,
    output tlvp_pkg::t_out_word  o_result
);

    logic [1:0]  r_phase, n_phase;
    logic [1:0]  r_kind,  n_kind;
    logic [7:0]  r_left,  n_left;
    logic [23:0] r_acc,   n_acc;
    logic        r_err,   n_err;

    logic               w_final;
    tlvp_pkg::t_out_word w_res;

    logic w_end;
    logic w_idle;
    logic w_fault;
    logic w_quiet;

    assign w_final = (r_left <= 8'd1);

    // Decode one word against the current phase
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_left  = r_left;
        n_acc   = r_acc;
        n_err   = r_err;
        w_res   = '0;
        w_res.message_end = i_word.last_byte;

        if (!r_err) begin
            case (r_phase)
                tlvp_pkg::PH_LEN: begin
                    if (r_kind == tlvp_pkg::K_PORT &&
                        i_word.data_byte != tlvp_pkg::PORT_LEN) begin
                        w_res.error_code = tlvp_pkg::ERR_PORT_LEN;
                    end else if (r_kind == tlvp_pkg::K_UPD &&
                                 i_word.data_byte != tlvp_pkg::BOOL_LEN) begin
                        w_res.error_code = tlvp_pkg::ERR_BOOL_LEN;
                    end else if ((r_kind == tlvp_pkg::K_HOST || r_kind == tlvp_pkg::K_PATH) &&
                                 i_word.data_byte == 8'd0) begin
                        w_res.event_kind   = tlvp_pkg::EV_EMPTY_END;
                        w_res.string_field = (r_kind == tlvp_pkg::K_PATH);
                        n_phase            = tlvp_pkg::PH_ID;
                    end else if (i_word.last_byte) begin
                        w_res.error_code = tlvp_pkg::ERR_TRUNC;
                    end else begin
                        n_left  = i_word.data_byte;
                        n_acc   = '0;
                        n_phase = tlvp_pkg::PH_VAL;
                    end
                end
                tlvp_pkg::PH_VAL: begin
                    if (i_word.last_byte && !w_final) begin
                        w_res.error_code = tlvp_pkg::ERR_TRUNC;
                    end else begin
                        case (r_kind)
                            tlvp_pkg::K_HOST, tlvp_pkg::K_PATH: begin
                                w_res.event_kind  = (r_kind == tlvp_pkg::K_HOST) ?
                                                    tlvp_pkg::EV_HOST_CHAR :
                                                    tlvp_pkg::EV_PATH_CHAR;
                                w_res.char_value  = i_word.data_byte;
                                w_res.string_last = w_final;
                            end
                            tlvp_pkg::K_PORT: begin
                                if (w_final) begin
                                    w_res.event_kind = tlvp_pkg::EV_PORT;
                                    w_res.port_value = {r_acc, i_word.data_byte};
                                end else begin
                                    n_acc = {r_acc[15:0], i_word.data_byte};
                                end
                            end
                            default: begin
                                w_res.event_kind  = tlvp_pkg::EV_UPDATE;
                                w_res.update_flag = (i_word.data_byte == 8'd1);
                            end
                        endcase
                        // Close the record or count down the value bytes
                        if (w_final) begin
                            n_left  = '0;
                            n_phase = tlvp_pkg::PH_ID;
                        end else begin
                            n_left = r_left - 8'd1;
                        end
                    end
                end
                default: begin
                    if (i_word.data_byte inside {tlvp_pkg::HOST_ID, tlvp_pkg::PORT_ID,
                                                 tlvp_pkg::PATH_ID, tlvp_pkg::UPDATE_ID}) begin
                        case (i_word.data_byte)
                            tlvp_pkg::HOST_ID: n_kind = tlvp_pkg::K_HOST;
                            tlvp_pkg::PORT_ID: n_kind = tlvp_pkg::K_PORT;
                            tlvp_pkg::PATH_ID: n_kind = tlvp_pkg::K_PATH;
                            default:           n_kind = tlvp_pkg::K_UPD;
                        endcase
                        if (i_word.last_byte) begin
                            w_res.error_code = tlvp_pkg::ERR_TRUNC;
                        end else begin
                            n_phase = tlvp_pkg::PH_LEN;
                        end
                    end else begin
                        w_res.error_code = tlvp_pkg::ERR_UNKNOWN;
                    end
                end
            endcase

            // Drop any partial result and latch the error
            if (w_res.error_code != tlvp_pkg::ERR_NONE) begin
                w_res.event_kind   = tlvp_pkg::EV_NONE;
                w_res.string_field = 1'b0;
                w_res.char_value   = '0;
                w_res.string_last  = 1'b0;
                w_res.port_value   = '0;
                w_res.update_flag  = 1'b0;
                n_err              = 1'b1;
            end
        end

        // Return to reset state at message end
        if (i_word.last_byte) begin
            n_phase = tlvp_pkg::PH_ID;
            n_kind  = tlvp_pkg::K_HOST;
            n_left  = '0;
            n_acc   = '0;
            n_err   = 1'b0;
        end
    end

    assign o_result = w_res;

    // Advance the parse state on each consumed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tlvp_pkg::PH_ID;
            r_kind  <= tlvp_pkg::K_HOST;
            r_left  <= '0;
            r_acc   <= '0;
            r_err   <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_left  <= n_left;
            r_acc   <= n_acc;
            r_err   <= n_err;
        end
    end

    // Terms of the checks below
    assign w_end   = i_advance && i_word.last_byte;
    assign w_idle  = (r_phase == tlvp_pkg::PH_ID) && !r_err && (r_left == 8'd0);
    assign w_fault = (o_result.error_code != tlvp_pkg::ERR_NONE);
    assign w_quiet = !w_fault && (o_result.event_kind == tlvp_pkg::EV_NONE);

    `ASSERT_CLK(a_end_clears, i_clk, i_rst_n, w_end |=> w_idle)
    `ASSERT_CLK(a_err_latches, i_clk, i_rst_n, (i_advance && !i_word.last_byte && w_fault) |=> r_err)
    `ASSERT_CLK(a_latched_quiet, i_clk, i_rst_n, r_err |-> w_quiet)
    `ASSERT_NEVER(a_err_no_event, i_clk, i_rst_n, w_fault && o_result.event_kind != tlvp_pkg::EV_NONE)

endmodule

// ----- rtl/core/tlv_update_response_parser_top.sv -----
// Top level of the TLV update-response parser: input and result registers.
// Depends on tlvp_pkg and tlvp_core.
//
// Usage: bytes of a response message enter on the input channel
// (i_in_valid / o_in_ready / i_in_word), one word per byte, with last_byte
// set on the final byte of the message. Each accepted word gives exactly
// one result word on the output channel (o_out_valid / i_out_ready /
// o_out_word), in order; event_kind 0 means the byte produced nothing.
// A word accepted into the input register has its result captured in the
// result register. Throughput: one word per cycle unless the receiver
// stalls; the parse state is a single small register set updated as each
// word leaves the input register.
// Reset clears both register stages and the parse state to expect an id.
// When the receiver stalls, the result register holds, the input register
// fills behind it, and o_in_ready drops; nothing is lost or repeated.
// An error latches until the word with last_byte set, then clears.

module tlv_update_response_parser_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tlvp_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tlvp_pkg::t_out_word  o_out_word
);

    logic                r_in_valid;
    tlvp_pkg::t_in_word  r_in_word;
    logic                r_out_valid;
    tlvp_pkg::t_out_word r_out_word;

    logic                w_out_free;
    logic                w_advance;
    tlvp_pkg::t_out_word w_result;

    // Move a word forward when the result register can take it
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_advance;

    tlvp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_word    (r_in_word),
        .o_result  (w_result)
    );

    // Track occupancy of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Capture payload words
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (w_advance) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
